// File: hdl/mbrtu_pkg.sv
// package for the modbus rtu polling master
// holds field widths, phase tables and shared status struct; no dependencies
`default_nettype none
package mbrtu_pkg;
   localparam int FrameBytesDefault = 96;
   localparam logic [7:0] FuncReadInput = 8'h04;
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [15:0] CrcInit = 16'hFFFF;

   typedef enum logic [2:0] {
      CSR_DEVICE_ADDRESS   = 3'd0,
      CSR_RESPONSE_TIMEOUT = 3'd1,
      CSR_FRAME_GAP        = 3'd2,
      CSR_FLUSH_TIME       = 3'd3,
      CSR_STALE_LIMIT      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       last;
      logic [1:0] phase;
      logic       frame_ok;
      logic       data_valid;
      logic [15:0] reading_0;
      logic [15:0] reading_1;
      logic [15:0] reading_2;
      logic [15:0] reading_3;
      logic [15:0] reading_4;
   } rsp_type;

   function automatic logic [15:0] phase_start(input logic [1:0] p);
      logic [15:0] r;
      unique case (p)
         2'd0: r = 16'd0;
         2'd1: r = 16'd35;
         2'd2: r = 16'd1000;
         default: r = 16'd55;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] phase_count(input logic [1:0] p);
      logic [15:0] r;
      unique case (p)
         2'd0: r = 16'd11;
         2'd1: r = 16'd7;
         2'd2: r = 16'd25;
         default: r = 16'd3;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// File: hdl/mbrtu_if.sv
// valid/ready channel interfaces for requests and responses
// depends on mbrtu_pkg for the response struct
`default_nettype none
interface mbrtu_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;
   modport source (output valid, func, rx_byte, input ready);
   modport sink (input valid, func, rx_byte, output ready);
endinterface

interface mbrtu_rsp_if import mbrtu_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hdl/mbrtu_crc.sv
// bit-serial crc-16 (modbus form), one bit per cycle
// depends on mbrtu_pkg
`default_nettype none
module mbrtu_crc import mbrtu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        init,
   input  wire logic        load,
   input  wire logic [7:0]  data,
   output logic             busy,
   output logic [15:0]      crc
);
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sh_ff, sh_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] x;

   // one bit of the byte shifted in per cycle
   always_comb begin
      crc_in = crc_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      x = crc_ff ^ {15'd0, sh_ff[0]};
      if (init) begin
         crc_in = CrcInit;
         cnt_in = 4'd0;
      end else if (load) begin
         sh_in  = data;
         cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         crc_in = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
         sh_in  = sh_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
         crc_ff <= CrcInit;
      end else begin
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
      end
      sh_ff <= sh_in;
   end

   assign busy = (cnt_ff != 4'd0);
   assign crc  = crc_ff;
endmodule
`default_nettype wire

// File: hdl/mbrtu_div10.sv
// serial unsigned divide of a 16-bit value by ten, one quotient bit per cycle
// depends on mbrtu_pkg
`default_nettype none
module mbrtu_div10 import mbrtu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   output logic             busy,
   output logic [15:0]      quotient
);
   logic [15:0] q_ff, q_in;
   logic [3:0]  r_ff, r_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  t;

   // restoring division: remainder stays below ten
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      t = {r_ff, q_ff[15]};
      if (start) begin
         q_in = dividend;
         r_in = 4'd0;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (t >= 5'd10) begin
            r_in = 4'(t - 5'd10);
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = t[3:0];
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy = (cnt_ff != 5'd0);
   assign quotient = q_ff;
endmodule
`default_nettype wire

// File: hdl/modbus_rtu_polling_master_core.sv
// modbus rtu polling master: input channel of ticks and bytes, output of request
// bytes and phase reports. A tick or byte that emits nothing leaves the block idle, so
// such items can follow back to back.
// A request runs the crc over the six header bytes (a load, then a shift per bit),
// then shows one byte per cycle while the receiver is ready. A frame end runs the
// crc over the stored bytes up to the crc field, checks the address, the exception
// bit and the crc, then makes up to 6 register reads and up to 4 serial divides.
// One item is worked at a time; req ready is low while an item is in work or
// a result waits. A stalled receiver holds the result register; the block
// waits. Reset is synchronous: configuration takes its defaults, the block
// starts flushing for phase 0, counters and the valid flag clear. The frame
// memory is not cleared; a word beyond the received length reads zero if the
// memory cell was never written since reset (tracked with per-entry valid
// bits).
// depends on mbrtu_pkg, mbrtu_if, mbrtu_crc, mbrtu_div10
`default_nettype none
module modbus_rtu_polling_master_core import mbrtu_pkg::*; #(
   parameter int FRAME_BYTES = FrameBytesDefault
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mbrtu_req_if.sink  req,
   mbrtu_rsp_if.source rsp,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_data
);
   localparam int LW = $clog2(FRAME_BYTES + 1);
   localparam int AW = $clog2(FRAME_BYTES);

   typedef enum logic [3:0] {
      S_IDLE, S_REQ_CRC, S_REQ_OUT, S_FIN_CHK, S_FIN_CRC, S_FIN_CMP,
      S_RD_ADDR, S_RD_HI, S_RD_LO, S_DIV, S_REPORT
   } state_type;

   // configuration
   logic [7:0]  addr_ff, tmo_ff, gap_ff, flush_ff;
   logic [19:0] stale_ff;
   // block state
   state_type   st_ff;
   logic [1:0]  phase_ff;
   logic        recv_ff, started_ff, valid_ff;
   logic [7:0]  flush_cnt_ff, since_send_ff, since_byte_ff;
   logic [LW-1:0] len_ff;
   logic [19:0] since_good_ff;
   // work registers
   logic [3:0]  idx_ff;
   logic [LW-1:0] pos_ff;
   logic [7:0]  b0_ff, b1_ff, crclo_ff;
   logic [15:0] word_ff;
   logic [2:0]  rd_ff;
   logic [15:0] rdv_ff [5];
   logic        ok_ff, rsp_valid_ff, div_go_ff;
   rsp_type     rsp_ff;
   // memory
   logic [7:0]  mem [FRAME_BYTES];
   logic [FRAME_BYTES-1:0] written_ff;
   logic [7:0]  mem_q_ff;
   logic        mem_qv_ff;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] rd_pos;

   logic        crc_init, crc_load, crc_busy;
   logic [7:0]  crc_data;
   logic [15:0] crc_val;
   logic        div_busy;
   logic [15:0] div_q;

   mbrtu_crc u_crc (.clock, .reset, .init(crc_init), .load(crc_load),
      .data(crc_data), .busy(crc_busy), .crc(crc_val));
   mbrtu_div10 u_div (.clock, .reset, .start(div_go_ff), .dividend(word_ff),
      .busy(div_busy), .quotient(div_q));

   // request header byte by index
   function automatic logic [7:0] req_byte(input logic [3:0] i, input logic [1:0] p,
                                           input logic [7:0] a, input logic [15:0] c);
      logic [7:0]  r;
      logic [15:0] s, n;
      s = phase_start(p);
      n = phase_count(p);
      unique case (i)
         4'd0: r = a;
         4'd1: r = FuncReadInput;
         4'd2: r = s[15:8];
         4'd3: r = s[7:0];
         4'd4: r = n[15:8];
         4'd5: r = n[7:0];
         4'd6: r = c[7:0];
         default: r = c[15:8];
      endcase
      return r;
   endfunction

   // register slot used by reading j of each phase; 31 means unused
   function automatic logic [4:0] reg_sel(input logic [1:0] p, input logic [2:0] j);
      logic [4:0] r;
      r = 5'd31;
      unique case (p)
         2'd0: if (j == 3'd0) r = 5'd6; else if (j == 3'd1) r = 5'd10;
         2'd1: if (j == 3'd0) r = 5'd1; else if (j == 3'd1) r = 5'd6;
         2'd2: unique case (j)
            3'd0: r = 5'd13;
            3'd1: r = 5'd14;
            3'd2: r = 5'd16;
            3'd3: r = 5'd24;
            3'd4: r = 5'd12;
            default: r = 5'd10;
         endcase
         default: if (j == 3'd0) r = 5'd2;
      endcase
      return r;
   endfunction

   function automatic logic needs_div(input logic [1:0] p, input logic [2:0] j);
      return !((p == 2'd3) || (p == 2'd2 && (j == 3'd0 || j == 3'd1)));
   endfunction

   logic [4:0] sel_reg;
   logic [8:0] byte_pos;
   assign sel_reg  = reg_sel(phase_ff, rd_ff);
   assign byte_pos = 9'd3 + {3'd0, sel_reg, 1'b0};
   // frame check starts by addressing byte 0
   assign rd_pos   = (st_ff == S_FIN_CHK) ? LW'(0) :
                     (st_ff == S_RD_HI) ? LW'(byte_pos + 9'd1) :
                     (st_ff == S_RD_ADDR) ? LW'(byte_pos) : pos_ff;
   assign rd_addr  = rd_pos[AW-1:0];

   assign req.ready = (st_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   logic acc;
   assign acc = req.valid && req.ready;
   logic store_byte;
   assign store_byte = acc && req.func && recv_ff && (started_ff || req.rx_byte != 8'd0)
                       && (len_ff < LW'(FRAME_BYTES));

   // frame memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (store_byte) mem[len_ff[AW-1:0]] <= req.rx_byte;
      mem_q_ff  <= mem[rd_addr];
      mem_qv_ff <= written_ff[rd_addr];
   end
   logic [7:0] mem_rd;
   assign mem_rd = mem_qv_ff ? mem_q_ff : 8'd0;

   // frame crc covers bytes 0 to length minus 3 only
   assign crc_init = (st_ff == S_IDLE);
   assign crc_load = ((st_ff == S_REQ_CRC) ||
                      ((st_ff == S_FIN_CRC) && (pos_ff != len_ff - LW'(2))))
                     && !crc_busy && !div_go_ff;
   assign crc_data = (st_ff == S_REQ_CRC) ? req_byte(idx_ff, phase_ff, addr_ff, crc_val)
                                         : mem_rd;

   logic tick_end, tmo_hit;
   logic [7:0] ss_next, sb_next;
   always_comb begin
      ss_next = (since_send_ff != 8'hFF) ? since_send_ff + 8'd1 : since_send_ff;
      sb_next = (started_ff && since_byte_ff != 8'hFF) ? since_byte_ff + 8'd1
                                                        : since_byte_ff;
      tmo_hit = (ss_next > tmo_ff) || (ss_next == 8'hFF);
      tick_end = tmo_hit || (started_ff && sb_next >= gap_ff);
   end

   // control and datapath sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= 8'd1; tmo_ff <= 8'd120; gap_ff <= 8'd5; flush_ff <= 8'd5;
         stale_ff <= 20'd60000;
         st_ff <= S_IDLE; phase_ff <= 2'd0; recv_ff <= 1'b0; started_ff <= 1'b0;
         valid_ff <= 1'b0; flush_cnt_ff <= 8'd0; since_send_ff <= 8'd0;
         since_byte_ff <= 8'd0; len_ff <= '0; since_good_ff <= 20'd0;
         rsp_valid_ff <= 1'b0; div_go_ff <= 1'b0; written_ff <= '0;
      end else begin
         div_go_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS:   addr_ff  <= csr_data[7:0];
               CSR_RESPONSE_TIMEOUT: tmo_ff   <= csr_data[7:0];
               CSR_FRAME_GAP:        gap_ff   <= csr_data[7:0];
               CSR_FLUSH_TIME:       flush_ff <= csr_data[7:0];
               CSR_STALE_LIMIT:      stale_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (store_byte) begin
            written_ff[len_ff[AW-1:0]] <= 1'b1;
            len_ff <= len_ff + 1'b1;
            started_ff <= 1'b1;
            since_byte_ff <= 8'd0;
         end
         unique case (st_ff)
            S_IDLE: if (acc && !req.func) begin
               if (since_good_ff != 20'hFFFFF) since_good_ff <= since_good_ff + 20'd1;
               if (!recv_ff) begin
                  if (flush_cnt_ff != 8'hFF) flush_cnt_ff <= flush_cnt_ff + 8'd1;
                  if (((flush_cnt_ff != 8'hFF) ? flush_cnt_ff + 8'd1 : flush_cnt_ff)
                      >= flush_ff) begin
                     idx_ff <= 4'd0;
                     st_ff <= S_REQ_CRC;
                  end
               end else begin
                  since_send_ff <= ss_next;
                  since_byte_ff <= sb_next;
                  if (tick_end) begin
                     ok_ff <= 1'b0;
                     for (int j = 0; j < 5; j++) rdv_ff[j] <= 16'd0;
                     st_ff <= S_FIN_CHK;
                  end
               end
            end
            S_REQ_CRC: if (crc_load) begin
               if (idx_ff == 4'd5) begin
                  idx_ff <= 4'd0;
                  st_ff <= S_REQ_OUT;
               end else begin
                  idx_ff <= idx_ff + 4'd1;
               end
            end
            S_REQ_OUT: if (!crc_busy && (!rsp_valid_ff || rsp.ready)) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '0;
               rsp_ff.tx_byte <= req_byte(idx_ff, phase_ff, addr_ff, crc_val);
               rsp_ff.last <= (idx_ff == 4'd7);
               rsp_ff.phase <= phase_ff;
               if (idx_ff == 4'd7) begin
                  recv_ff <= 1'b1; since_send_ff <= 8'd0; since_byte_ff <= 8'd0;
                  started_ff <= 1'b0; len_ff <= '0; flush_cnt_ff <= 8'd0;
                  st_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 4'd1;
               end
            end
            S_FIN_CHK: begin
               // header check uses byte 0 then byte 1 via the read port
               pos_ff <= '0;
               b0_ff <= 8'd0;
               if (len_ff < LW'(5)) st_ff <= S_REPORT;
               else begin
                  st_ff <= S_FIN_CRC;
               end
            end
            S_FIN_CRC: if (crc_load || (crc_busy == 1'b0 && pos_ff == len_ff - LW'(2))) begin
               // memory read data for pos_ff arrives in the cycle after its address
               if (pos_ff == len_ff - LW'(2)) begin
                  pos_ff <= pos_ff;
                  st_ff <= S_FIN_CMP;
                  idx_ff <= 4'd0;
               end else begin
                  if (pos_ff == LW'(0)) b0_ff <= mem_rd;
                  if (pos_ff == LW'(1)) b1_ff <= mem_rd;
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            S_FIN_CMP: begin
               // read crc low, then high, then compare
               idx_ff <= idx_ff + 4'd1;
               if (idx_ff == 4'd0) pos_ff <= pos_ff + 1'b1;
               if (idx_ff == 4'd1) crclo_ff <= mem_rd;
               if (idx_ff == 4'd2) begin
                  if (b0_ff == addr_ff && !b1_ff[7] && crclo_ff == crc_val[7:0]
                      && mem_rd == crc_val[15:8]) begin
                     ok_ff <= 1'b1;
                     rd_ff <= 3'd0;
                     st_ff <= S_RD_ADDR;
                  end else st_ff <= S_REPORT;
               end
            end
            S_RD_ADDR: begin
               if (rd_ff == 3'd6 || (sel_reg == 5'd31)) st_ff <= S_REPORT;
               else st_ff <= S_RD_HI;
            end
            S_RD_HI: begin
               word_ff[15:8] <= mem_rd;
               st_ff <= S_RD_LO;
            end
            S_RD_LO: begin
               word_ff[7:0] <= mem_rd;
               if (needs_div(phase_ff, rd_ff)) begin
                  div_go_ff <= 1'b1;
                  st_ff <= S_DIV;
               end else begin
                  rdv_ff[rd_ff] <= (rd_ff == 3'd1) ? {8'd0, mem_rd} : {word_ff[15:8], mem_rd};
                  rd_ff <= rd_ff + 3'd1;
                  st_ff <= S_RD_ADDR;
               end
            end
            S_DIV: if (!div_go_ff && !div_busy) begin
               if (rd_ff == 3'd5) rdv_ff[4] <= rdv_ff[4] - div_q;
               else rdv_ff[rd_ff] <= div_q;
               rd_ff <= rd_ff + 3'd1;
               st_ff <= S_RD_ADDR;
            end
            S_REPORT: if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.kind <= 1'b1;
               rsp_ff.tx_byte <= 8'd0;
               rsp_ff.last <= 1'b1;
               rsp_ff.phase <= phase_ff;
               rsp_ff.frame_ok <= ok_ff;
               rsp_ff.data_valid <= ok_ff ? 1'b1 : (valid_ff && since_good_ff <= stale_ff);
               rsp_ff.reading_0 <= rdv_ff[0];
               rsp_ff.reading_1 <= rdv_ff[1];
               rsp_ff.reading_2 <= rdv_ff[2];
               rsp_ff.reading_3 <= rdv_ff[3];
               rsp_ff.reading_4 <= rdv_ff[4];
               if (ok_ff) begin
                  since_good_ff <= 20'd0;
                  valid_ff <= 1'b1;
               end else if (since_good_ff > stale_ff) valid_ff <= 1'b0;
               phase_ff <= phase_ff + 2'd1;
               recv_ff <= 1'b0;
               flush_cnt_ff <= 8'd0;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // a result never appears while an item is being accepted
   assert property (@(posedge clock) disable iff (reset) acc |-> !rsp_valid_ff)
      else $error("item accepted with result pending");
   // a stalled result holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("held result changed");
   // frame length never passes the store depth
   assert property (@(posedge clock) disable iff (reset) len_ff <= LW'(FRAME_BYTES))
      else $error("frame length overflow");
   // reports leave the block in the flush state
   assert property (@(posedge clock) disable iff (reset)
      st_ff == S_REPORT && (!rsp_valid_ff || rsp.ready) |=> !recv_ff)
      else $error("report did not end receive");
endmodule
`default_nettype wire
